// ----- rtl/bdc_pkg.sv -----
// Package for the business day counter: field widths, reciprocal constants,
// sequencer step codes and the calendar lookup functions.
// No dependencies; imported by every module of the block.
package bdc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int MASK_W  = 7;

  localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;

  // Shared multiply-add unit: p = c +/- a * b.
  localparam int OPA_W = 22;
  localparam int OPB_W = 23;
  localparam int OPC_W = 22;
  localparam int P_W   = 46;

  // Day serial numbers and quotients held between steps.
  localparam int DN_W  = 22;
  localparam int Q_W   = 19;
  localparam int YQ_W  = 8;
  localparam int WD_W  = 3;

  // Division by 100 and by 7 through reciprocal multiplication.
  localparam logic [OPB_W-1:0] RECIP_100    = 23'd5243;
  localparam int               RECIP_100_SH = 19;
  localparam logic [OPB_W-1:0] RECIP_7      = 23'd4793491;
  localparam int               RECIP_7_SH   = 25;

  localparam logic [OPB_W-1:0] MUL_ONE      = 23'd1;
  localparam logic [OPB_W-1:0] MUL_SEVEN    = 23'd7;
  localparam logic [OPB_W-1:0] MUL_HUNDRED  = 23'd100;
  localparam logic [OPB_W-1:0] DAYS_PER_YR  = 23'd365;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_LQ   = 14'b00000000000010,
    ST_LR   = 14'b00000000000100,
    ST_YQ   = 14'b00000000001000,
    ST_D1   = 14'b00000000010000,
    ST_D2   = 14'b00000000100000,
    ST_D3   = 14'b00000001000000,
    ST_NSUB = 14'b00000010000000,
    ST_NINC = 14'b00000100000000,
    ST_WQ   = 14'b00001000000000,
    ST_WR   = 14'b00010000000000,
    ST_NQ   = 14'b00100000000000,
    ST_NR   = 14'b01000000000000,
    ST_CNT  = 14'b10000000000000
  } step_t;

  typedef struct packed {
    step_t step;
    logic  side;   // 0 while working on the start date, 1 on the end date
  } seq_ctl_t;

  // Days before the first of month mm, counted from March 1 (mm 0 is March).
  function automatic logic [8:0] month_offset(input logic [MON_W-1:0] mm);
    logic [8:0] off;
    unique case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/bdc_mac.sv -----
// Shared multiply-add unit of the business day counter: p = c + a*b or c - a*b.
// Combinational; uses widths from bdc_pkg.
module bdc_mac import bdc_pkg::*; (
  input  logic [OPA_W-1:0] op_a,
  input  logic [OPB_W-1:0] op_b,
  input  logic [OPC_W-1:0] op_c,
  input  logic             sub,
  output logic [P_W-1:0]   p
);

  logic [OPA_W+OPB_W-1:0] prod;
  logic [P_W-1:0]         prod_ext;
  logic [P_W-1:0]         c_ext;

  assign prod     = op_a * op_b;
  assign prod_ext = P_W'(prod);
  assign c_ext    = P_W'(op_c);
  assign p        = sub ? (c_ext - prod_ext) : (c_ext + prod_ext);

endmodule

// ----- rtl/bdc_seq.sv -----
// Step sequencer of the business day counter: walks the fixed list of
// multiply-add steps for both dates and the span. Uses bdc_pkg.
module bdc_seq import bdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output seq_ctl_t ctl
);

  step_t state_r, state_nxt;
  logic  side_r, side_nxt;

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LQ;
          side_nxt  = 1'b0;
        end
      end
      ST_LQ:   state_nxt = ST_LR;
      ST_LR:   state_nxt = ST_YQ;
      ST_YQ:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_D3;
      ST_D3: begin
        if (side_r) begin
          state_nxt = ST_NSUB;
        end else begin
          state_nxt = ST_LQ;
          side_nxt  = 1'b1;
        end
      end
      ST_NSUB: state_nxt = ST_NINC;
      ST_NINC: state_nxt = ST_WQ;
      ST_WQ:   state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_NQ;
      ST_NQ:   state_nxt = ST_NR;
      ST_NR:   state_nxt = ST_CNT;
      ST_CNT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign ctl.step = state_r;
  assign ctl.side = side_r;

endmodule

// ----- rtl/business_day_counter_core.sv -----
// Top level of the business day counter: input capture, datapath registers
// and result register around the shared multiply-add unit and the sequencer.
// Depends on bdc_pkg, bdc_mac and bdc_seq.

// An item (start date and end date) is taken at a rising edge where start is
// high and busy is low. Busy then stays high while the steps run; in the
// first cycle with busy low again the result is shown for exactly one
// cycle with out_valid high, and a new item may be started in that same
// cycle, not before. The single multiply-add unit does one operation per
// cycle: six per date and seven for the span and the count. The receiver
// cannot stall, so the result must be taken in its strobe cycle.
// The weekend mask (reset value marks Friday and Saturday) is written through
// the cfg channel, which is always ready; write it only while busy is low and
// no result is pending. An invalid date gives a count of zero with bad_date
// set, and a start date after the end date gives a count of zero.
module business_day_counter_core import bdc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  in_start_year,
  input  logic [MON_W-1:0]   in_start_month,
  input  logic [DAY_W-1:0]   in_start_day,
  input  logic [YEAR_W-1:0]  in_end_year,
  input  logic [MON_W-1:0]   in_end_month,
  input  logic [DAY_W-1:0]   in_end_day,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MASK_W-1:0]  cfg_weekend_mask,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_business_days,
  output logic               out_bad_date
);

  seq_ctl_t ctl;
  logic     accept;

  bdc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // Captured item.
  logic [YEAR_W-1:0] sy_r, ey_r, sy_nxt, ey_nxt;
  logic [MON_W-1:0]  sm_r, em_r, sm_nxt, em_nxt;
  logic [DAY_W-1:0]  sd_r, ed_r, sd_nxt, ed_nxt;

  // Working registers. Quotients of all divisions share q_r.
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [DN_W-1:0]    acc_r, acc_nxt;
  logic [DN_W-1:0]    dn_s_r, dn_s_nxt;
  logic [Q_W-1:0]     q_r, q_nxt;
  logic [WD_W-1:0]    w0_r, w0_nxt;
  logic [WD_W-1:0]    rest_r, rest_nxt;
  logic               leap_r, leap_nxt;
  logic               bad_r, bad_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_days_r, out_days_nxt;
  logic               out_bad_r, out_bad_nxt;

  // The date being worked on and its March-based year and month.
  logic [YEAR_W-1:0] cur_y, yy;
  logic [MON_W-1:0]  cur_m, mm;
  logic [DAY_W-1:0]  cur_d;
  logic              early;
  logic              date_ok;
  logic [9:0]        td;
  logic [YQ_W-1:0]   yq;

  assign cur_y = ctl.side ? ey_r : sy_r;
  assign cur_m = ctl.side ? em_r : sm_r;
  assign cur_d = ctl.side ? ed_r : sd_r;

  // January and February count as months of the previous year.
  assign early = (cur_m <= 4'd2);
  assign yy    = cur_y - YEAR_W'(early);
  assign mm    = early ? (cur_m + 4'd9) : (cur_m - 4'd3);
  assign td    = 10'(month_offset(mm)) + 10'(cur_d);
  assign yq    = q_r[YQ_W-1:0];

  assign date_ok = (cur_y >= YEAR_MIN) && (cur_y <= YEAR_MAX) &&
                   (cur_m != 4'd0) && (cur_m <= MON_MAX) &&
                   (cur_d != 5'd0) && (cur_d <= month_days(cur_m, leap_r));

  // Days of the leftover partial week: rotate the open-day mask so that bit 0
  // is the start weekday, then keep the first rest_r days.
  logic [MASK_W-1:0]   open_mask;
  logic [2*MASK_W-1:0] open_twice;
  logic [MASK_W-1:0]   open_rot;
  logic [MASK_W-1:0]   rest_sel;
  logic [WD_W-1:0]     open_per_week;
  logic [WD_W-1:0]     extra_days;

  assign open_mask     = ~mask_r;
  assign open_twice    = {open_mask, open_mask};
  assign open_rot      = open_twice[{1'b0, w0_r} +: MASK_W];
  assign rest_sel      = MASK_W'((8'd1 << rest_r) - 8'd1);
  assign open_per_week = WD_W'($countones(open_mask));
  assign extra_days    = WD_W'($countones(open_rot & rest_sel));

  // Shared multiply-add unit and its operand selection.
  logic [OPA_W-1:0] op_a;
  logic [OPB_W-1:0] op_b;
  logic [OPC_W-1:0] op_c;
  logic             op_sub;
  logic [P_W-1:0]   p;

  bdc_mac u_mac (
    .op_a (op_a),
    .op_b (op_b),
    .op_c (op_c),
    .sub  (op_sub),
    .p    (p)
  );

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_c   = '0;
    op_sub = 1'b0;
    unique case (ctl.step)
      ST_LQ: begin
        // y / 100
        op_a = OPA_W'(cur_y);
        op_b = RECIP_100;
      end
      ST_LR: begin
        // y % 100
        op_a   = OPA_W'(yq);
        op_b   = MUL_HUNDRED;
        op_c   = OPC_W'(cur_y);
        op_sub = 1'b1;
      end
      ST_YQ: begin
        // yy / 100
        op_a = OPA_W'(yy);
        op_b = RECIP_100;
      end
      ST_D1: begin
        op_a = OPA_W'(yy);
        op_b = DAYS_PER_YR;
        op_c = OPC_W'(yy >> 2);
      end
      ST_D2: begin
        // Minus yy/100, plus yy/400.
        op_a   = OPA_W'(yq - (yq >> 2));
        op_b   = MUL_ONE;
        op_c   = acc_r;
        op_sub = 1'b1;
      end
      ST_D3: begin
        op_a = OPA_W'(td);
        op_b = MUL_ONE;
        op_c = acc_r;
      end
      ST_NSUB: begin
        op_a   = dn_s_r;
        op_b   = MUL_ONE;
        op_c   = acc_r;
        op_sub = 1'b1;
      end
      ST_NINC: begin
        op_a = OPA_W'(1);
        op_b = MUL_ONE;
        op_c = acc_r;
      end
      ST_WQ: begin
        op_a = dn_s_r;
        op_b = RECIP_7;
      end
      ST_WR: begin
        op_a   = OPA_W'(q_r);
        op_b   = MUL_SEVEN;
        op_c   = dn_s_r;
        op_sub = 1'b1;
      end
      ST_NQ: begin
        op_a = acc_r;
        op_b = RECIP_7;
      end
      ST_NR: begin
        op_a   = OPA_W'(q_r);
        op_b   = MUL_SEVEN;
        op_c   = acc_r;
        op_sub = 1'b1;
      end
      ST_CNT: begin
        // Whole weeks times open days per week, plus the partial week.
        op_a = OPA_W'(q_r);
        op_b = OPB_W'(open_per_week);
        op_c = OPC_W'(extra_days);
      end
      default: begin
        op_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    sy_nxt        = sy_r;
    sm_nxt        = sm_r;
    sd_nxt        = sd_r;
    ey_nxt        = ey_r;
    em_nxt        = em_r;
    ed_nxt        = ed_r;
    mask_nxt      = mask_r;
    acc_nxt       = acc_r;
    dn_s_nxt      = dn_s_r;
    q_nxt         = q_r;
    w0_nxt        = w0_r;
    rest_nxt      = rest_r;
    leap_nxt      = leap_r;
    bad_nxt       = bad_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_days_nxt  = out_days_r;
    out_bad_nxt   = out_bad_r;

    if (cfg_valid && cfg_ready) begin
      mask_nxt = cfg_weekend_mask;
    end

    unique case (ctl.step)
      ST_IDLE: begin
        if (accept) begin
          sy_nxt  = in_start_year;
          sm_nxt  = in_start_month;
          sd_nxt  = in_start_day;
          ey_nxt  = in_end_year;
          em_nxt  = in_end_month;
          ed_nxt  = in_end_day;
          bad_nxt = 1'b0;
        end
      end
      ST_LQ: begin
        q_nxt = Q_W'(p[RECIP_100_SH +: YQ_W]);
      end
      ST_LR: begin
        // Leap when divisible by 4, except centuries not divisible by 400.
        leap_nxt = (cur_y[1:0] == 2'd0) &&
                   ((p[6:0] != 7'd0) || (yq[1:0] == 2'd0));
      end
      ST_YQ: begin
        q_nxt   = Q_W'(p[RECIP_100_SH +: YQ_W]);
        bad_nxt = bad_r | ~date_ok;
      end
      ST_D1, ST_D2: begin
        acc_nxt = p[DN_W-1:0];
      end
      ST_D3: begin
        acc_nxt = p[DN_W-1:0];
        if (!ctl.side) begin
          dn_s_nxt = p[DN_W-1:0];
        end
      end
      ST_NSUB: begin
        acc_nxt = p[DN_W-1:0];
        neg_nxt = p[P_W-1];
      end
      ST_NINC: begin
        acc_nxt = p[DN_W-1:0];
      end
      ST_WQ, ST_NQ: begin
        q_nxt = p[RECIP_7_SH +: Q_W];
      end
      ST_WR: begin
        // The serial number is offset so that weekday = (number + 2) mod 7.
        unique case (p[WD_W-1:0])
          3'd5:    w0_nxt = 3'd0;
          3'd6:    w0_nxt = 3'd1;
          default: w0_nxt = p[WD_W-1:0] + 3'd2;
        endcase
      end
      ST_NR: begin
        rest_nxt = p[WD_W-1:0];
      end
      ST_CNT: begin
        out_valid_nxt = 1'b1;
        out_bad_nxt   = bad_r;
        out_days_nxt  = (bad_r || neg_r) ? '0 : p[COUNT_W-1:0];
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sy_r       <= sy_nxt;
    sm_r       <= sm_nxt;
    sd_r       <= sd_nxt;
    ey_r       <= ey_nxt;
    em_r       <= em_nxt;
    ed_r       <= ed_nxt;
    acc_r      <= acc_nxt;
    dn_s_r     <= dn_s_nxt;
    q_r        <= q_nxt;
    w0_r       <= w0_nxt;
    rest_r     <= rest_nxt;
    leap_r     <= leap_nxt;
    bad_r      <= bad_nxt;
    neg_r      <= neg_nxt;
    out_days_r <= out_days_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_business_days = out_days_r;
  assign out_bad_date      = out_bad_r;

endmodule

// ----- rtl/bdc_checker.sv -----
// Port-level checker for the business day counter and its bind statement.
// Depends on bdc_pkg and business_day_counter_core.
module bdc_checker import bdc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [COUNT_W-1:0] out_business_days,
  input logic               out_bad_date
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // A result only appears once the block has finished its item.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // A result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A bad date always reports an empty count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_date) |-> (out_business_days == '0))
    else $error("nonzero count with a bad date");

endmodule

bind business_day_counter_core bdc_checker u_bdc_checker (.*);
